>>> hdl/htrm_pkg.sv
// Shared types, constants and the divide-by-ADC-full-scale helper for the
// heater thermal runaway monitor. No dependencies.
`default_nettype none

package htrm_pkg;

    // Field and register widths
    localparam int RAW_W      = 10;
    localparam int FS_W       = 13;
    localparam int TGT_W      = 13;
    localparam int TEMP_W     = 14;
    localparam int TO_S_W     = 16;
    localparam int TO_MS_W    = 26;   // 65535 s * 1000 fits in 26 bits
    localparam int TIME_W     = 32;
    localparam int PROD_W     = RAW_W + FS_W;
    localparam int Q_W        = 13;   // quotient below the rail never exceeds 8182
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [RAW_W-1:0]         ADC_MAX           = 10'd1023;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_X10      = 14'sd2800;
    localparam logic signed [TEMP_W-1:0] SENSOR_ERR_X10    = -14'sd100;
    localparam logic signed [TEMP_W-1:0] IDLE_TEMP_X10     = 14'sd220;
    localparam logic [TEMP_W-1:0]        RUNAWAY_DELTA_X10 = 14'd150;
    localparam logic signed [TEMP_W:0]   MIN_RISE_X10      = 15'sd40;
    localparam logic [TO_MS_W-1:0]       MS_PER_S          = 26'd1000;

    // Register indexes on the write port
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROTECT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MONITOR    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE = 3'd4;

    // Reset values
    localparam logic [TGT_W-1:0]   RST_TARGET     = 13'd0;
    localparam logic [TO_MS_W-1:0] RST_TIMEOUT_MS = 26'd40000;
    localparam logic [FS_W-1:0]    RST_FULL_SCALE = 13'd3000;

    typedef enum logic [1:0] {
        ALARM_NONE      = 2'd0,
        ALARM_OVER_TEMP = 2'd1,
        ALARM_RUNAWAY   = 2'd2,
        ALARM_TIMEOUT   = 2'd3
    } alarm_t;

    typedef struct packed {
        logic [TGT_W-1:0]   target_temp_x10;
        logic               protect_enable;
        logic               monitor_enable;
        logic [TO_MS_W-1:0] timeout_ms;
        logic [FS_W-1:0]    full_scale_x10;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_x10;
        logic                     sensor_fault;
        logic                     heater_on;
        logic [TIME_W-1:0]        now_ms;
    } meas_t;

    // floor(p / 1023): 1/1023 = 2^-10 + 2^-20 + ..., the truncated sum lands
    // on the quotient or one below it, and one remainder check fixes that.
    function automatic logic [Q_W-1:0] div_adc_max(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        logic [Q_W-1:0]    q;
        logic [PROD_W:0]   qm;
        logic [PROD_W:0]   r;
        s  = p + (p >> 10) + (p >> 20);
        q  = s[PROD_W-1:10];
        qm = {1'b0, q, 10'b0} - {11'b0, q};
        r  = {1'b0, p} - qm;
        if (r >= {14'd0, ADC_MAX})
        begin
            q = q + 1'b1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

>>> hdl/htrm_cfg.sv
// Configuration register file of the thermal runaway monitor.
// Depends on htrm_pkg; the timeout is kept in milliseconds.
`default_nettype none

module htrm_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [htrm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [htrm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output htrm_pkg::cfg_t                        cfg
);
    import htrm_pkg::*;

    cfg_t cfg_reg;
    logic [TO_MS_W-1:0] timeout_ms_next;

    // seconds to milliseconds once, at write time
    assign timeout_ms_next = TO_MS_W'(cfg_wdata[TO_S_W-1:0]) * MS_PER_S;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp_x10 <= RST_TARGET;
            cfg_reg.protect_enable  <= 1'b1;
            cfg_reg.monitor_enable  <= 1'b1;
            cfg_reg.timeout_ms      <= RST_TIMEOUT_MS;
            cfg_reg.full_scale_x10  <= RST_FULL_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TARGET:     cfg_reg.target_temp_x10 <= cfg_wdata[TGT_W-1:0];
                CFG_PROTECT:    cfg_reg.protect_enable  <= cfg_wdata[0];
                CFG_MONITOR:    cfg_reg.monitor_enable  <= cfg_wdata[0];
                CFG_TIMEOUT:    cfg_reg.timeout_ms      <= timeout_ms_next;
                CFG_FULL_SCALE: cfg_reg.full_scale_x10  <= cfg_wdata[FS_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hdl/htrm_convert.sv
// ADC-to-temperature pipeline: input register, product register, temperature
// register. Depends on htrm_pkg (div_adc_max, meas_t).
`default_nettype none

module htrm_convert (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire htrm_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [htrm_pkg::RAW_W-1:0]    raw_sample,
    input  wire logic                          heater_on,
    input  wire logic [htrm_pkg::TIME_W-1:0]   now_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output htrm_pkg::meas_t                    meas
);
    import htrm_pkg::*;

    logic load1, load2, load3;

    // stage 1: input register
    logic               v1_reg;
    logic [RAW_W-1:0]   raw1_reg;
    logic               heater1_reg;
    logic [TIME_W-1:0]  now1_reg;

    // stage 2: product
    logic               v2_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [PROD_W-1:0]  prod2_next;
    logic               rail2_reg;
    logic               rail2_next;
    logic               fault2_reg;
    logic               fault2_next;
    logic               heater2_reg;
    logic [TIME_W-1:0]  now2_reg;

    // stage 3: temperature
    logic               v3_reg;
    meas_t              meas3_reg;
    meas_t              meas3_next;
    logic [Q_W-1:0]     quot;

    assign load3    = !v3_reg || out_ready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    assign prod2_next  = PROD_W'(raw1_reg) * PROD_W'(cfg.full_scale_x10);
    assign rail2_next  = (raw1_reg == '0) || (raw1_reg == ADC_MAX);
    assign fault2_next = rail2_next && (cfg.target_temp_x10 != '0);

    assign quot = div_adc_max(prod2_reg);

    always_comb
    begin
        meas3_next.temp_x10     = rail2_reg ? SENSOR_ERR_X10 : $signed({1'b0, quot});
        meas3_next.sensor_fault = fault2_reg;
        meas3_next.heater_on    = heater2_reg;
        meas3_next.now_ms       = now2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= in_valid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            raw1_reg    <= raw_sample;
            heater1_reg <= heater_on;
            now1_reg    <= now_ms;
        end
        if (load2)
        begin
            prod2_reg   <= prod2_next;
            rail2_reg   <= rail2_next;
            fault2_reg  <= fault2_next;
            heater2_reg <= heater1_reg;
            now2_reg    <= now1_reg;
        end
        if (load3)
        begin
            meas3_reg <= meas3_next;
        end
    end

    assign out_valid = v3_reg;
    assign meas      = meas3_reg;

endmodule

`default_nettype wire

>>> hdl/htrm_check.sv
// Protection checks, heating-period state and the result register.
// Depends on htrm_pkg (cfg_t, meas_t, alarm_t).
`default_nettype none

module htrm_check (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire htrm_pkg::cfg_t                  cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire htrm_pkg::meas_t                 meas,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output htrm_pkg::alarm_t                     alarm,
    output logic                                 sensor_fault,
    output logic signed [htrm_pkg::TEMP_W-1:0]   temp_x10
);
    import htrm_pkg::*;

    logic load;

    logic                      out_v_reg;
    alarm_t                    alarm_reg;
    alarm_t                    alarm_next;
    logic                      fault_reg;
    logic                      fault_next;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic signed [TEMP_W-1:0]  temp_next;

    logic                      was_on_reg;
    logic                      was_on_next;
    logic [TIME_W-1:0]         start_ms_reg;
    logic [TIME_W-1:0]         start_ms_next;
    logic signed [TEMP_W-1:0]  start_temp_reg;
    logic signed [TEMP_W-1:0]  start_temp_next;

    logic signed [TEMP_W:0]    temp_ext;
    logic signed [TEMP_W:0]    limit_ext;
    logic signed [TEMP_W:0]    rise;
    logic [TIME_W-1:0]         elapsed;
    logic                      timed_out;
    logic                      over_temp;
    logic                      runaway;

    assign in_ready = !out_v_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign temp_ext  = {meas.temp_x10[TEMP_W-1], meas.temp_x10};
    assign limit_ext = $signed({1'b0, TEMP_W'(cfg.target_temp_x10) + RUNAWAY_DELTA_X10});
    assign rise      = temp_ext - {start_temp_reg[TEMP_W-1], start_temp_reg};
    assign elapsed   = meas.now_ms - start_ms_reg;
    assign timed_out = elapsed >= TIME_W'(cfg.timeout_ms);
    assign over_temp = meas.temp_x10 > MAX_TEMP_X10;
    assign runaway   = (cfg.target_temp_x10 != '0) && (temp_ext > limit_ext);

    always_comb
    begin
        alarm_next      = ALARM_NONE;
        fault_next      = meas.sensor_fault;
        temp_next       = meas.temp_x10;
        was_on_next     = was_on_reg;
        start_ms_next   = start_ms_reg;
        start_temp_next = start_temp_reg;
        if (!cfg.monitor_enable)
        begin
            fault_next = 1'b0;
            temp_next  = IDLE_TEMP_X10;
        end
        else if (!cfg.protect_enable)
        begin
            // report only
        end
        else if (over_temp)
        begin
            alarm_next = ALARM_OVER_TEMP;
        end
        else if (runaway)
        begin
            alarm_next = ALARM_RUNAWAY;
        end
        else if (meas.heater_on)
        begin
            if (!was_on_reg)
            begin
                was_on_next     = 1'b1;
                start_ms_next   = meas.now_ms;
                start_temp_next = meas.temp_x10;
            end
            else if (timed_out)
            begin
                if (rise < MIN_RISE_X10)
                begin
                    alarm_next = ALARM_TIMEOUT;
                end
                else
                begin
                    start_ms_next   = meas.now_ms;
                    start_temp_next = meas.temp_x10;
                end
            end
        end
        else
        begin
            was_on_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg      <= 1'b0;
            was_on_reg     <= 1'b0;
            start_ms_reg   <= '0;
            start_temp_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                out_v_reg <= in_valid;
            end
            if (load)
            begin
                was_on_reg     <= was_on_next;
                start_ms_reg   <= start_ms_next;
                start_temp_reg <= start_temp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            alarm_reg <= alarm_next;
            fault_reg <= fault_next;
            temp_reg  <= temp_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign alarm        = alarm_reg;
    assign sensor_fault = fault_reg;
    assign temp_x10     = temp_reg;

    // a timeout alarm never rebases the heating period
    a_timeout_no_rebase: assert property (@(posedge clk) disable iff (!rst_n)
        load && (alarm_next == ALARM_TIMEOUT) |=>
            $stable(start_ms_reg) && $stable(start_temp_reg))
        else $error("heating period rebased on timeout alarm");

    a_monitor_off: assert property (@(posedge clk) disable iff (!rst_n)
        load && !cfg.monitor_enable |=>
            (alarm_reg == ALARM_NONE) && !fault_reg && (temp_reg == IDLE_TEMP_X10))
        else $error("monitor disabled but result not idle");

    a_fault_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && fault_reg |-> temp_reg == SENSOR_ERR_X10)
        else $error("sensor fault without rail temperature");

    a_was_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(was_on_reg) |-> $past(load && !meas.heater_on))
        else $error("heater period cleared without heater-off request");

endmodule

`default_nettype wire

>>> hdl/heater_thermal_runaway_monitor_top.sv
// Heater thermal runaway monitor, top level: config registers, conversion
// pipeline and protection check. Depends on htrm_pkg, htrm_cfg,
// htrm_convert and htrm_check.
//
// Path: a request accepted on s_axis reaches m_axis through the input,
// product, temperature and result registers.
// Throughput: one request per cycle unless stalled; every stage holds its own
// valid bit, so bubbles fill while the result register waits on m_axis_tready.
// Reset (rst_n, async, low): pipeline empty, heating period cleared, and the
// registers at target 0, protect on, monitor on, 40 s timeout, 300.0 C scale.
`default_nettype none

module heater_thermal_runaway_monitor_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request: [9:0] raw_sample, [10] heater_on, [42:11] now_ms, [47:43] zero
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [htrm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // result: [1:0] alarm, [2] sensor_fault, [16:3] temp_x10, [23:17] zero
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [htrm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // register write port, index as listed in htrm_pkg
    input  wire logic                              cfg_we,
    input  wire logic [htrm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [htrm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import htrm_pkg::*;

    cfg_t                     cfg;
    meas_t                    meas;
    logic                     meas_valid;
    logic                     meas_ready;
    alarm_t                   alarm;
    logic                     sensor_fault;
    logic signed [TEMP_W-1:0] temp_x10;

    htrm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // raw * full_scale, then / 1023, with rail samples forced to -10.0 C
    htrm_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .raw_sample (s_axis_tdata[RAW_W-1:0]),
        .heater_on  (s_axis_tdata[RAW_W]),
        .now_ms     (s_axis_tdata[RAW_W+TIME_W:RAW_W+1]),
        .out_valid  (meas_valid),
        .out_ready  (meas_ready),
        .meas       (meas)
    );

    // alarm priority and the heating-period state; state moves only when a
    // request enters the result register, so it sees requests in order
    htrm_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (meas_valid),
        .in_ready     (meas_ready),
        .meas         (meas),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .alarm        (alarm),
        .sensor_fault (sensor_fault),
        .temp_x10     (temp_x10)
    );

    assign m_axis_tdata = {7'b0, temp_x10, sensor_fault, alarm};

endmodule

`default_nettype wire
